/* hw/rtl/mme_pkg.sv */
// ----------------------------------------------------------------------------
// mme_pkg
// Shared types and codes for the matrix multiply engine: operation codes,
// register indexes, sequencer states and the tag that follows each
// multiply-accumulate step down the pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package mme_pkg;

   // field widths
   localparam int OP_W    = 2;
   localparam int IDX_W   = 3;
   localparam int ELEM_W  = 16;
   localparam int PROD_W  = 32;
   localparam int SUM_W   = 40;
   localparam int COUNT_W = 4;
   localparam int CSR_W   = 2;

   // largest count an index field can address
   localparam int INDEX_SPAN = 8;

   // operation codes carried in tuser
   localparam logic [OP_W-1:0] OP_LOAD_A  = 2'd0;
   localparam logic [OP_W-1:0] OP_LOAD_B  = 2'd1;
   localparam logic [OP_W-1:0] OP_COMPUTE = 2'd2;

   // register indexes
   localparam logic [CSR_W-1:0] CSR_ROW_COUNT   = 2'd0;
   localparam logic [CSR_W-1:0] CSR_INNER_COUNT = 2'd1;
   localparam logic [CSR_W-1:0] CSR_COL_COUNT   = 2'd2;

   localparam logic [COUNT_W-1:0] COUNT_RESET = 4'd8;

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } mme_state_type;

   // control that travels with one multiply-accumulate step
   typedef struct packed {
      logic             valid;
      logic [IDX_W-1:0] row;
      logic [IDX_W-1:0] col;
      logic             first_k;
      logic             last_k;
      logic             last_elem;
   } mme_tag_type;

   // last loop index for a count register: zero acts as one, large values clip
   function automatic logic [IDX_W-1:0] count_last(input logic [COUNT_W-1:0] cnt,
                                                   input logic [COUNT_W-1:0] lim);
      logic [COUNT_W-1:0] eff;
      if (cnt == '0) begin
         eff = 4'd1;
      end else if (cnt > lim) begin
         eff = lim;
      end else begin
         eff = cnt;
      end
      count_last = IDX_W'(eff - 4'd1);
   endfunction

endpackage

`default_nettype wire

/* hw/rtl/mme_mac.sv */
// ----------------------------------------------------------------------------
// mme_mac
// Multiply-accumulate datapath: registers the Q16.16 product of Q8.8 operands, then adds it into
// a 40-bit accumulator that restarts on the first inner step of each element.
// ----------------------------------------------------------------------------
`default_nettype none

module mme_mac (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        advance,
   input  wire mme_pkg::mme_tag_type        tag_in,
   input  wire logic signed [15:0]          a_value,
   input  wire logic signed [15:0]          b_value,
   output mme_pkg::mme_tag_type             tag_out,
   output logic                             done,
   output logic [39:0]                      sum_out
);
   import mme_pkg::*;

   mme_tag_type              tag_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;
   logic [SUM_W-1:0]         acc_ff;
   logic [SUM_W-1:0]         acc_in;

   // product of the two operands, exact in 32 bits
   assign prod_in = a_value * b_value;

   // running sum, restarted on the first inner step
   always_comb begin
      acc_in = (tag_ff.first_k ? '0 : acc_ff)
               + {{(SUM_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
   end

   // product stage and accumulator
   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff.valid <= 1'b0;
      end else if (advance) begin
         tag_ff.valid <= tag_in.valid;
      end
      if (advance) begin
         tag_ff.row       <= tag_in.row;
         tag_ff.col       <= tag_in.col;
         tag_ff.first_k   <= tag_in.first_k;
         tag_ff.last_k    <= tag_in.last_k;
         tag_ff.last_elem <= tag_in.last_elem;
         prod_ff          <= prod_in;
         if (tag_ff.valid) begin
            acc_ff <= acc_in;
         end
      end
   end

   assign tag_out = tag_ff;
   assign done    = tag_ff.valid && tag_ff.last_k;
   assign sum_out = acc_in;

endmodule

`default_nettype wire

/* hw/rtl/matrix_multiply_engine.sv */
// Load words (operation 0 or 1) are accepted while idle and give no result.
// A compute holds req_tready low while it walks the two matrix memories, one read
// of each per cycle unless a finished result is stalled at the output; the results
// follow in row-major order, one per element of C.
// Reset: synchronous; counts return to 8, pipeline and output register empty,
// matrix memories are not cleared.
// ----------------------------------------------------------------------------
// matrix_multiply_engine
// Matrix product C = A x B on Q8.8 elements held in two synchronous memories,
// with exact 40-bit Q24.16 sums emitted in row-major order.
// ----------------------------------------------------------------------------
`default_nettype none

module matrix_multiply_engine #(
   parameter int MAX_DIM = 8
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // input words
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,   // row_index[2:0], col_index[5:3], element_value[21:6]
   input  wire logic [1:0]  req_tuser,   // operation[1:0]
   // result words
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [47:0]      rsp_tdata,   // out_row[2:0], out_col[5:3], product_sum[45:6]
   output logic             rsp_tlast,
   // register writes
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [3:0]  csr_data
);
   import mme_pkg::*;

   localparam int DEPTH  = MAX_DIM * MAX_DIM;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int LIMIT  = (MAX_DIM < INDEX_SPAN) ? MAX_DIM : INDEX_SPAN;
   localparam logic [COUNT_W-1:0] LIMIT_COUNT = COUNT_W'(LIMIT);

   // input fields
   logic [OP_W-1:0]          req_op;
   logic [IDX_W-1:0]         req_row;
   logic [IDX_W-1:0]         req_col;
   logic signed [ELEM_W-1:0] req_value;
   logic                     req_accept;
   logic                     load_in_range;
   logic [ADDR_W-1:0]        wr_addr;

   // registers
   logic [COUNT_W-1:0] row_count_ff;
   logic [COUNT_W-1:0] inner_count_ff;
   logic [COUNT_W-1:0] col_count_ff;

   // sequencer
   mme_state_type    state_ff, state_in;
   logic [IDX_W-1:0] i_ff, i_in, j_ff, j_in, k_ff, k_in;
   logic [IDX_W-1:0] ni_ff, ni_in, nj_ff, nj_in, nk_ff, nk_in;
   logic             last_i, last_j, last_k;
   logic             advance;
   logic             issue;

   // memories and read stage
   logic signed [ELEM_W-1:0] left_mem  [DEPTH];
   logic signed [ELEM_W-1:0] right_mem [DEPTH];
   logic signed [ELEM_W-1:0] a_rd_ff, b_rd_ff;
   logic [ADDR_W-1:0]        a_addr, b_addr;
   mme_tag_type              rd_tag_ff, rd_tag_in;

   // accumulate stage
   mme_tag_type      mac_tag;
   logic             mac_done;
   logic [SUM_W-1:0] mac_sum;

   // output register
   logic             rsp_valid_ff;
   logic [IDX_W-1:0] rsp_row_ff, rsp_col_ff;
   logic [SUM_W-1:0] rsp_sum_ff;
   logic             rsp_last_ff;

   assign req_op    = req_tuser;
   assign req_row   = req_tdata[2:0];
   assign req_col   = req_tdata[5:3];
   assign req_value = req_tdata[21:6];

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   // pipeline moves unless a finished word is stuck at the output
   assign advance = !rsp_valid_ff || rsp_tready;
   assign issue   = (state_ff == ST_RUN) && advance;

   // load address; writes outside the store are dropped
   assign load_in_range = (int'(req_row) < MAX_DIM) && (int'(req_col) < MAX_DIM);
   assign wr_addr = ADDR_W'(int'(req_row) * MAX_DIM + int'(req_col));

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff   <= COUNT_RESET;
         inner_count_ff <= COUNT_RESET;
         col_count_ff   <= COUNT_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_ROW_COUNT:   row_count_ff   <= csr_data;
            CSR_INNER_COUNT: inner_count_ff <= csr_data;
            CSR_COL_COUNT:   col_count_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   // walk over i, j, k
   assign last_i = (i_ff == ni_ff);
   assign last_j = (j_ff == nj_ff);
   assign last_k = (k_ff == nk_ff);

   always_comb begin
      state_in = state_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      k_in     = k_ff;
      ni_in    = ni_ff;
      nj_in    = nj_ff;
      nk_in    = nk_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept && req_op == OP_COMPUTE) begin
               ni_in    = count_last(row_count_ff, LIMIT_COUNT);
               nk_in    = count_last(inner_count_ff, LIMIT_COUNT);
               nj_in    = count_last(col_count_ff, LIMIT_COUNT);
               i_in     = '0;
               j_in     = '0;
               k_in     = '0;
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (advance) begin
               if (!last_k) begin
                  k_in = k_ff + 1'b1;
               end else begin
                  k_in = '0;
                  if (!last_j) begin
                     j_in = j_ff + 1'b1;
                  end else begin
                     j_in = '0;
                     if (!last_i) begin
                        i_in = i_ff + 1'b1;
                     end else begin
                        state_in = ST_IDLE;
                     end
                  end
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      i_ff  <= i_in;
      j_ff  <= j_in;
      k_ff  <= k_in;
      ni_ff <= ni_in;
      nj_ff <= nj_in;
      nk_ff <= nk_in;
   end

   // read addresses: A[i][k] and B[k][j]
   assign a_addr = ADDR_W'(int'(i_ff) * MAX_DIM + int'(k_ff));
   assign b_addr = ADDR_W'(int'(k_ff) * MAX_DIM + int'(j_ff));

   always_comb begin
      rd_tag_in.valid     = issue;
      rd_tag_in.row       = i_ff;
      rd_tag_in.col       = j_ff;
      rd_tag_in.first_k   = (k_ff == '0);
      rd_tag_in.last_k    = last_k;
      rd_tag_in.last_elem = last_i && last_j;
   end

   // left matrix memory
   always_ff @(posedge clock) begin
      if (req_accept && req_op == OP_LOAD_A && load_in_range) begin
         left_mem[wr_addr] <= req_value;
      end
      if (issue) begin
         a_rd_ff <= left_mem[a_addr];
      end
   end

   // right matrix memory
   always_ff @(posedge clock) begin
      if (req_accept && req_op == OP_LOAD_B && load_in_range) begin
         right_mem[wr_addr] <= req_value;
      end
      if (issue) begin
         b_rd_ff <= right_mem[b_addr];
      end
   end

   // read stage tag
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_tag_ff.valid <= 1'b0;
      end else if (advance) begin
         rd_tag_ff.valid <= rd_tag_in.valid;
      end
      if (advance) begin
         rd_tag_ff.row       <= rd_tag_in.row;
         rd_tag_ff.col       <= rd_tag_in.col;
         rd_tag_ff.first_k   <= rd_tag_in.first_k;
         rd_tag_ff.last_k    <= rd_tag_in.last_k;
         rd_tag_ff.last_elem <= rd_tag_in.last_elem;
      end
   end

   mme_mac u_mac (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .tag_in  (rd_tag_ff),
      .a_value (a_rd_ff),
      .b_value (b_rd_ff),
      .tag_out (mac_tag),
      .done    (mac_done),
      .sum_out (mac_sum)
   );

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= mac_done;
      end
      if (advance && mac_done) begin
         rsp_row_ff  <= mac_tag.row;
         rsp_col_ff  <= mac_tag.col;
         rsp_sum_ff  <= mac_sum;
         rsp_last_ff <= mac_tag.last_elem;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_sum_ff, rsp_col_ff, rsp_row_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule

`default_nettype wire
